### hw/rtl/sos_pkg.sv
// Shared constants for the slice order sequencer.
package sos_pkg;

  // Table depth and derived widths
  localparam int MAX_SLICES = 64;
  localparam int SLICE_W    = $clog2(MAX_SLICES);
  localparam int CNT_W      = $clog2(MAX_SLICES + 1);

  // Step and velocity payload widths
  localparam int STEP_W     = 32;
  localparam int VEL_W      = 16;
  localparam int DIV_CNT_W  = $clog2(STEP_W);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int SC_W       = 7;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE  = 4'd1;

  // Order modes
  localparam logic [MODE_W-1:0] MODE_FORWARD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOM  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd3;

  // LCG and seed constants
  localparam logic [31:0] SEED_MUL = 32'd2654435761;
  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_ADD  = 32'd1013904223;

endpackage

### hw/rtl/slice_order_sequencer.sv
// Slice order sequencer: maps a step number to the slice to play.
//
// Input channel: step_number_i / velocity_code_i, handshake in_valid_i and
// in_stall_o; a beat is taken when valid is high and stall is low. Output
// channel: slice_index_o / velocity_out_o, handshake out_valid_o and
// out_stall_i. Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i
// (0 slice count, 1 order mode) and cfg_data_i; other indexes are ignored.
// One item is worked on at a time. Forward, reverse and random steps go
// through the radix-2 remainder unit that wraps the step (or the LCG value)
// by the slice count. A shuffle step reads the permutation memory instead.
// When the effective count or mode differs from the last rebuild, a rebuild
// runs first: the identity table fills one entry per cycle, then in shuffle
// mode each Fisher-Yates swap takes an LCG step, a remainder, two reads and
// two writes on the single-port-write table memory.
// Reset returns the registers to count 1 / forward mode and forces a rebuild
// at the first step. While the receiver stalls, the finished result holds in
// the output register; the next item is still accepted and waits in its
// final state until the output register frees up.
module slice_order_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sos_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sos_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input beats
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [sos_pkg::STEP_W-1:0] step_number_i,
  input  logic [sos_pkg::VEL_W-1:0]         velocity_code_i,
  // result beats
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sos_pkg::SLICE_W-1:0]       slice_index_o,
  output logic [sos_pkg::VEL_W-1:0]         velocity_out_o
);

  localparam int SLICE_W = sos_pkg::SLICE_W;
  localparam int CNT_W   = sos_pkg::CNT_W;
  localparam int STEP_W  = sos_pkg::STEP_W;
  localparam int VEL_W   = sos_pkg::VEL_W;
  localparam int DCW     = sos_pkg::DIV_CNT_W;
  localparam int MODE_W  = sos_pkg::MODE_W;
  localparam int SC_W    = sos_pkg::SC_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_LCG    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_RD_I   = 4'd5;
  localparam logic [3:0] S_RD_J   = 4'd6;
  localparam logic [3:0] S_WR_I   = 4'd7;
  localparam logic [3:0] S_WR_J   = 4'd8;
  localparam logic [3:0] S_RESEED = 4'd9;
  localparam logic [3:0] S_STEP   = 4'd10;
  localparam logic [3:0] S_TBL    = 4'd11;
  localparam logic [3:0] S_FIX    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  // Control registers
  logic [3:0]        state_q, state_d;
  logic [SC_W-1:0]   slice_count_q, slice_count_d;
  logic [MODE_W-1:0] order_mode_q, order_mode_d;
  logic [CNT_W-1:0]  seen_count_q, seen_count_d;
  logic [MODE_W-1:0] seen_mode_q, seen_mode_d;
  logic [SLICE_W-1:0] ptr_q, ptr_d;
  logic [31:0]       lcg_q, lcg_d;
  logic              out_valid_q, out_valid_d;

  // Payload / datapath registers
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [VEL_W-1:0]   vel_q, vel_d;
  logic               rebuild_q, rebuild_d;
  logic [SLICE_W-1:0] fill_q, fill_d;
  logic [SLICE_W-1:0] i_q, i_d;
  logic [SLICE_W-1:0] j_q, j_d;
  logic [SLICE_W-1:0] vi_q, vi_d;
  logic [STEP_W-1:0]  div_num_q, div_num_d;
  logic [CNT_W-1:0]   div_den_q, div_den_d;
  logic [SLICE_W-1:0] div_rem_q, div_rem_d;
  logic [DCW-1:0]     div_cnt_q, div_cnt_d;
  logic               div_swap_q, div_swap_d;
  logic [SLICE_W-1:0] res_q, res_d;
  logic [SLICE_W-1:0] out_slice_q, out_slice_d;
  logic [VEL_W-1:0]   out_vel_q, out_vel_d;

  // Permutation table memory
  logic [SLICE_W-1:0] perm_mem [sos_pkg::MAX_SLICES];
  logic [SLICE_W-1:0] mem_rdata_q;
  logic [SLICE_W-1:0] mem_raddr, mem_waddr, mem_wdata;
  logic               mem_we;

  // Combinational helpers
  logic [CNT_W-1:0]   eff_count;
  logic [31:0]        seed_w, lcg_nx;
  logic [SLICE_W:0]   div_t;
  logic               div_ge;
  logic [SLICE_W-1:0] div_rem_nx;
  logic [CNT_W-1:0]   wrap_w;
  logic [CNT_W-1:0]   ptr_inc;
  logic               in_take, out_free;

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign slice_index_o  = out_slice_q;
  assign velocity_out_o = out_vel_q;

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Clamp the written count into 1..MAX_SLICES
  always_comb begin
    if (slice_count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (int'(slice_count_q) > sos_pkg::MAX_SLICES) begin
      eff_count = CNT_W'(sos_pkg::MAX_SLICES);
    end else begin
      eff_count = CNT_W'(slice_count_q);
    end
  end

  assign seed_w = 32'(32'(cnt_q) * sos_pkg::SEED_MUL + 32'd1);
  assign lcg_nx = 32'(lcg_q * sos_pkg::LCG_MUL + sos_pkg::LCG_ADD);

  // One restoring remainder step per cycle
  assign div_t      = {div_rem_q, div_num_q[STEP_W-1]};
  assign div_ge     = div_t >= (SLICE_W+1)'(div_den_q);
  assign div_rem_nx = div_ge ? SLICE_W'(div_t - (SLICE_W+1)'(div_den_q)) : SLICE_W'(div_t);

  // Floor-modulo correction for negative steps
  assign wrap_w = (step_q[STEP_W-1] && div_rem_q != '0) ?
                  CNT_W'(cnt_q - CNT_W'(div_rem_q)) : CNT_W'(div_rem_q);

  assign ptr_inc = CNT_W'(ptr_q) + CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    slice_count_d = slice_count_q;
    order_mode_d  = order_mode_q;
    seen_count_d  = seen_count_q;
    seen_mode_d   = seen_mode_q;
    ptr_d         = ptr_q;
    lcg_d         = lcg_q;
    out_valid_d   = out_valid_q;
    cnt_d         = cnt_q;
    mode_d        = mode_q;
    step_d        = step_q;
    vel_d         = vel_q;
    rebuild_d     = rebuild_q;
    fill_d        = fill_q;
    i_d           = i_q;
    j_d           = j_q;
    vi_d          = vi_q;
    div_num_d     = div_num_q;
    div_den_d     = div_den_q;
    div_rem_d     = div_rem_q;
    div_cnt_d     = div_cnt_q;
    div_swap_d    = div_swap_q;
    res_d         = res_q;
    out_slice_d   = out_slice_q;
    out_vel_d     = out_vel_q;
    mem_raddr     = ptr_q;
    mem_waddr     = fill_q;
    mem_wdata     = fill_q;
    mem_we        = 1'b0;

    // Configuration writes; unknown indexes drop
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sos_pkg::CFG_SLICE_COUNT: slice_count_d = cfg_data_i[SC_W-1:0];
        sos_pkg::CFG_ORDER_MODE:  order_mode_d  = cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end

    // Result leaves the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          cnt_d     = eff_count;
          mode_d    = order_mode_q;
          step_d    = step_number_i;
          vel_d     = velocity_code_i;
          rebuild_d = (eff_count != seen_count_q) || (order_mode_q != seen_mode_q);
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rebuild_q) begin
          seen_count_d = cnt_q;
          seen_mode_d  = mode_q;
          ptr_d        = '0;
          lcg_d        = seed_w;
          fill_d       = '0;
          state_d      = S_FILL;
        end else begin
          state_d = S_STEP;
        end
      end
      S_FILL: begin
        // Identity fill, one entry a cycle
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        mem_wdata = fill_q;
        fill_d    = fill_q + SLICE_W'(1);
        if (CNT_W'(fill_q) == cnt_q - CNT_W'(1)) begin
          if (mode_q == sos_pkg::MODE_SHUFFLE && cnt_q > CNT_W'(1)) begin
            i_d     = SLICE_W'(cnt_q - CNT_W'(1));
            state_d = S_LCG;
          end else begin
            state_d = S_RESEED;
          end
        end
      end
      S_LCG: begin
        lcg_d      = lcg_nx;
        div_num_d  = lcg_nx;
        div_den_d  = CNT_W'(i_q) + CNT_W'(1);
        div_rem_d  = '0;
        div_cnt_d  = '0;
        div_swap_d = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        div_rem_d = div_rem_nx;
        div_num_d = {div_num_q[STEP_W-2:0], 1'b0};
        div_cnt_d = div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(STEP_W - 1)) begin
          if (div_swap_q) begin
            j_d     = div_rem_nx;
            state_d = S_RD_I;
          end else begin
            state_d = S_FIX;
          end
        end
      end
      S_RD_I: begin
        mem_raddr = i_q;
        state_d   = S_RD_J;
      end
      S_RD_J: begin
        mem_raddr = j_q;
        vi_d      = mem_rdata_q;
        state_d   = S_WR_I;
      end
      S_WR_I: begin
        // table[i] takes the old table[j]
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = mem_rdata_q;
        state_d   = S_WR_J;
      end
      S_WR_J: begin
        // table[j] takes the old table[i]; same entry is harmless
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = vi_q;
        if (i_q == SLICE_W'(1)) begin
          state_d = S_RESEED;
        end else begin
          i_d     = i_q - SLICE_W'(1);
          state_d = S_LCG;
        end
      end
      S_RESEED: begin
        lcg_d   = seed_w;
        state_d = S_STEP;
      end
      S_STEP: begin
        div_den_d  = cnt_q;
        div_rem_d  = '0;
        div_cnt_d  = '0;
        div_swap_d = 1'b0;
        case (mode_q)
          sos_pkg::MODE_FORWARD, sos_pkg::MODE_REVERSE: begin
            div_num_d = step_q[STEP_W-1] ? STEP_W'(-step_q) : step_q;
            state_d   = S_DIV;
          end
          sos_pkg::MODE_RANDOM: begin
            lcg_d     = lcg_nx;
            div_num_d = lcg_nx;
            state_d   = S_DIV;
          end
          sos_pkg::MODE_SHUFFLE: begin
            mem_raddr = ptr_q;
            ptr_d     = (ptr_inc >= cnt_q) ? '0 : SLICE_W'(ptr_inc);
            state_d   = S_TBL;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_TBL: begin
        res_d   = mem_rdata_q;
        state_d = S_OUT;
      end
      S_FIX: begin
        case (mode_q)
          sos_pkg::MODE_REVERSE: res_d = SLICE_W'(cnt_q - CNT_W'(1) - wrap_w);
          sos_pkg::MODE_RANDOM:  res_d = div_rem_q;
          default:               res_d = SLICE_W'(wrap_w);
        endcase
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slice_d = res_q;
          out_vel_d   = vel_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slice_count_q <= SC_W'(1);
      order_mode_q  <= sos_pkg::MODE_FORWARD;
      seen_count_q  <= '0;
      seen_mode_q   <= '0;
      ptr_q         <= '0;
      lcg_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      slice_count_q <= slice_count_d;
      order_mode_q  <= order_mode_d;
      seen_count_q  <= seen_count_d;
      seen_mode_q   <= seen_mode_d;
      ptr_q         <= ptr_d;
      lcg_q         <= lcg_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    mode_q      <= mode_d;
    step_q      <= step_d;
    vel_q       <= vel_d;
    rebuild_q   <= rebuild_d;
    fill_q      <= fill_d;
    i_q         <= i_d;
    j_q         <= j_d;
    vi_q        <= vi_d;
    div_num_q   <= div_num_d;
    div_den_q   <= div_den_d;
    div_rem_q   <= div_rem_d;
    div_cnt_q   <= div_cnt_d;
    div_swap_q  <= div_swap_d;
    res_q       <= res_d;
    out_slice_q <= out_slice_d;
    out_vel_q   <= out_vel_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= perm_mem[mem_raddr];
  end

endmodule

### hw/rtl/sos_checker.sv
// Port-level checks for the slice order sequencer, bound to the top level.
module sos_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [sos_pkg::SLICE_W-1:0]       slice_index_o,
  input logic [sos_pkg::VEL_W-1:0]         velocity_out_o
);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(slice_index_o) && $stable(velocity_out_o))
    else $error("stalled result changed");

  // One item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // No result can appear in the cycle right after an accept
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared without work");

endmodule

bind slice_order_sequencer sos_checker u_sos_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .slice_index_o  (slice_index_o),
  .velocity_out_o (velocity_out_o)
);
